[rtl/core/quoted_argument_tokenizer_unit_assert.svh]
// Assertion macros for the quoted argument tokenizer.
// Uses the clk and rst_n names of the including module; empty under SYNTH.
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Checked only while the block is out of reset.
`define QATU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer assertion failed");

// Checked on every edge, reset included.
`define QATU_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tokenizer assertion failed during reset");

`else

`define QATU_ASSERT(label, prop)
`define QATU_ASSERT_ALWAYS(label, prop)

`endif

`endif

[rtl/core/qatu_pkg.sv]
// Shared types and constants of the quoted argument tokenizer.
// No dependencies; used by the channel interfaces and the top level.
package qatu_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_WORD_END = 2'd1,
        KIND_LINE_END = 2'd2
    } kind_t;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_EOL  = 1'b1
    } op_t;

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       last;
    } result_t;

    // Tokenizer state carried from one byte to the next.
    typedef struct packed {
        logic in_quotes;
        logic quote_is_single;
        logic escape_pending;
        logic word_nonempty;
    } tok_state_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

endpackage

[rtl/core/qatu_cmd_if.sv]
// Input channel of the tokenizer: one command-line byte or an end of line per beat.
// Depends on qatu_pkg.
interface qatu_cmd_if;
    logic            valid;
    logic            ready;
    qatu_pkg::op_t   operation;
    logic [7:0]      char_in;

    modport source (output valid, output operation, output char_in, input ready);
    modport sink   (input valid, input operation, input char_in, output ready);
endinterface

[rtl/core/qatu_tok_if.sv]
// Output channel of the tokenizer: one word character, word end or line end per beat.
// Depends on qatu_pkg.
interface qatu_tok_if;
    logic            valid;
    logic            ready;
    qatu_pkg::kind_t kind;
    logic [7:0]      char_out;
    logic            last;

    modport source (output valid, output kind, output char_out, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input last, output ready);
endinterface

[rtl/core/quoted_argument_tokenizer_unit.sv]
// Top level of the quoted argument tokenizer: shell-style word splitter.
// Depends on qatu_pkg, qatu_cmd_if, qatu_tok_if and the assertion macro header.
//
// Bytes of a command line enter on cmd, one per beat, and come out on tok as
// a stream of word characters, word ends and line ends. Whitespace outside
// quotes ends a non-empty word, a single or double quote opens a span that
// only the same quote closes and closing it always ends a word, and a
// backslash before a quote gives the quote alone while before any other byte
// it gives both bytes. An end-of-line beat flushes the pending word, emits a
// line end and clears all state. The input beat is held in a register and
// decoded, once the result buffer has room, into a two-entry result buffer
// that drives tok. Items that give at most one result go through at one per
// cycle while tok is ready; an item that gives two results (an escape or a
// flushed end of line) holds back the decode of the next input until both
// have left through the single result port. The first result is offered once
// the input beat has passed the input register and been decoded into the buffer.
`include "quoted_argument_tokenizer_unit_assert.svh"

module quoted_argument_tokenizer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    qatu_cmd_if.sink   cmd,
    qatu_tok_if.source tok
);

    // Input register.
    logic                 in_vld_reg;
    qatu_pkg::op_t        in_op_reg;
    logic [7:0]           in_ch_reg;

    // Tokenizer state.
    qatu_pkg::tok_state_t st_reg;
    qatu_pkg::tok_state_t st_next;

    // Result buffer: slot0 is presented, slot1 follows it.
    logic [1:0]           pend_cnt_reg;
    logic [1:0]           pend_cnt_next;
    qatu_pkg::result_t    slot0_reg;
    qatu_pkg::result_t    slot1_reg;
    qatu_pkg::result_t    slot0_next;
    qatu_pkg::result_t    slot1_next;

    qatu_pkg::result_t    res0;
    qatu_pkg::result_t    res1;
    logic [1:0]           res_cnt;
    logic [7:0]           closer;
    logic                 out_fire;
    logic                 process;

    assign out_fire = tok.valid && tok.ready;
    // The held byte is decoded once the buffer is empty or drains this cycle.
    assign process  = in_vld_reg &&
                      ((pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && out_fire));
    assign cmd.ready = !in_vld_reg || process;

    assign tok.valid    = (pend_cnt_reg != 2'd0);
    assign tok.kind     = slot0_reg.kind;
    assign tok.char_out = slot0_reg.ch;
    assign tok.last     = slot0_reg.last;

    assign closer = st_reg.quote_is_single ? qatu_pkg::CH_SQUOTE : qatu_pkg::CH_DQUOTE;

    // Decode of the held byte against the current state.
    always_comb
    begin
        st_next = st_reg;
        res0    = '{kind: qatu_pkg::KIND_CHAR, ch: 8'h00, last: 1'b1};
        res1    = '{kind: qatu_pkg::KIND_CHAR, ch: 8'h00, last: 1'b1};
        res_cnt = 2'd0;

        if (in_op_reg == qatu_pkg::OP_EOL)
        begin
            if (st_reg.word_nonempty)
            begin
                res0.kind = qatu_pkg::KIND_WORD_END;
                res1.kind = qatu_pkg::KIND_LINE_END;
                res_cnt   = 2'd2;
            end
            else
            begin
                res0.kind = qatu_pkg::KIND_LINE_END;
                res_cnt   = 2'd1;
            end
            st_next = '0;
        end
        else if (st_reg.escape_pending)
        begin
            st_next.escape_pending = 1'b0;
            st_next.word_nonempty  = 1'b1;
            if (!qatu_pkg::is_quote(in_ch_reg))
            begin
                res0.ch  = qatu_pkg::CH_BACKSLASH;
                res1.ch  = in_ch_reg;
                res_cnt  = 2'd2;
            end
            else
            begin
                res0.ch  = in_ch_reg;
                res_cnt  = 2'd1;
            end
        end
        else if (st_reg.in_quotes)
        begin
            if (in_ch_reg == closer)
            begin
                st_next.in_quotes     = 1'b0;
                st_next.word_nonempty = 1'b0;
                res0.kind = qatu_pkg::KIND_WORD_END;
                res_cnt   = 2'd1;
            end
            else if (in_ch_reg == qatu_pkg::CH_BACKSLASH)
            begin
                st_next.escape_pending = 1'b1;
            end
            else
            begin
                st_next.word_nonempty = 1'b1;
                res0.ch = in_ch_reg;
                res_cnt = 2'd1;
            end
        end
        else
        begin
            if (qatu_pkg::is_blank(in_ch_reg))
            begin
                if (st_reg.word_nonempty)
                begin
                    st_next.word_nonempty = 1'b0;
                    res0.kind = qatu_pkg::KIND_WORD_END;
                    res_cnt   = 2'd1;
                end
            end
            else if (qatu_pkg::is_quote(in_ch_reg))
            begin
                st_next.in_quotes       = 1'b1;
                st_next.quote_is_single = (in_ch_reg == qatu_pkg::CH_SQUOTE);
            end
            else if (in_ch_reg == qatu_pkg::CH_BACKSLASH)
            begin
                st_next.escape_pending = 1'b1;
            end
            else
            begin
                st_next.word_nonempty = 1'b1;
                res0.ch = in_ch_reg;
                res_cnt = 2'd1;
            end
        end

        res0.last = (res_cnt == 2'd1);
    end

    // Result buffer next state.
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        slot0_next    = slot0_reg;
        slot1_next    = slot1_reg;
        if (process)
        begin
            pend_cnt_next = res_cnt;
            slot0_next    = res0;
            slot1_next    = res1;
        end
        else if (out_fire)
        begin
            pend_cnt_next = pend_cnt_reg - 2'd1;
            slot0_next    = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            st_reg       <= '0;
            pend_cnt_reg <= 2'd0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_vld_reg <= cmd.valid;
            end
            if (process)
            begin
                st_reg <= st_next;
            end
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_op_reg <= cmd.operation;
            in_ch_reg <= cmd.char_in;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // A full buffer holds the first of a pair, then the final beat of the item.
    `QATU_ASSERT(a_pair_order, (pend_cnt_reg == 2'd2) |-> (!slot0_reg.last && slot1_reg.last))
    // A beat that is not the last of its item is always followed by another.
    `QATU_ASSERT(a_pair_follows, (out_fire && !tok.last) |=> tok.valid)
    // End of line leaves the tokenizer state fully cleared.
    `QATU_ASSERT(a_eol_clears, (process && (in_op_reg == qatu_pkg::OP_EOL)) |=> (st_reg == '0))
    // The matching closer always ends a quoted span when no escape is pending.
    `QATU_ASSERT(a_quote_close, (process && (in_op_reg == qatu_pkg::OP_CHAR)
        && st_reg.in_quotes && !st_reg.escape_pending && (in_ch_reg == closer))
        |=> (!st_reg.in_quotes && tok.valid && (tok.kind == qatu_pkg::KIND_WORD_END)))
    // Once reset has been seen at an edge, nothing is offered on the result side.
    `QATU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !tok.valid)

endmodule
